// ----- src/assert_macros.svh -----
// Assertion macros shared by the encoder period meter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define EPM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("epm assertion failed");

// condition must never be seen outside reset
`define EPM_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("epm forbidden condition seen");

`endif

// ----- src/epm_pkg.sv -----
// Types and constants for the encoder period meter
package epm_pkg;

  localparam int NUM_BINS_DEF   = 8;
  localparam int TIMER_BITS_DEF = 16;

  // field widths
  localparam int CMD_W   = 2;
  localparam int CAP_W   = 16;
  localparam int STAMP_W = 32;
  localparam int HIGH_W  = 16;
  localparam int BIN_W   = 4;
  localparam int RPM_W   = 32;

  // configuration widths
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int TPM_W     = 32;
  localparam int GEAR_W    = 10;
  localparam int PPR_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TPM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PPR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CEIL  = 3'd4;

  localparam logic [TPM_W-1:0]   TPM_RST   = 32'd1200000000;
  localparam logic [GEAR_W-1:0]  GEAR_RST  = 10'd59;
  localparam logic [PPR_W-1:0]   PPR_RST   = 16'd512;
  localparam logic [STAMP_W-1:0] FLOOR_RST = 32'd10000;
  localparam logic [STAMP_W-1:0] CEIL_RST  = 32'd25000;

  localparam logic [CMD_W-1:0] CMD_WRAP    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SERVICE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd2;

  // RPM arithmetic
  localparam int GP_W  = GEAR_W + PPR_W;
  localparam int NUM_W = TPM_W + 4;
  localparam int DEN_W = GP_W + STAMP_W;
  localparam logic [3:0] RPM_SCALE = 4'd10;

  // shared divider
  localparam int DIV_W  = 32;
  localparam int REM_W  = DEN_W + 1;
  localparam int STEP_W = 6;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DIV_W-1:0]  dividend;
    logic [DEN_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

// ----- src/epm_if.sv -----
// Valid/ready channel interfaces for event input and measurement output
interface epm_in_if;
  logic                      valid;
  logic                      ready;
  logic [epm_pkg::CMD_W-1:0] command;
  logic [epm_pkg::CAP_W-1:0] capture_value;

  modport source (output valid, command, capture_value, input ready);
  modport sink   (input valid, command, capture_value, output ready);
endinterface

interface epm_out_if;
  logic                        valid;
  logic                        ready;
  logic [epm_pkg::STAMP_W-1:0] period_ticks;
  logic [epm_pkg::BIN_W-1:0]   period_bin;
  logic [epm_pkg::RPM_W-1:0]   speed_rpm;
  logic                        went_backwards;

  modport source (output valid, period_ticks, period_bin, speed_rpm, went_backwards,
                  input ready);
  modport sink   (input valid, period_ticks, period_bin, speed_rpm, went_backwards,
                  output ready);
endinterface

// ----- src/epm_stamp.sv -----
// Timestamp extension and period tracking per event
module epm_stamp #(
  parameter int TIMER_BITS = epm_pkg::TIMER_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        ev_valid_i,
  input  logic [epm_pkg::CMD_W-1:0]   command_i,
  input  logic [epm_pkg::CAP_W-1:0]   capture_value_i,
  output logic [epm_pkg::STAMP_W-1:0] period_o,
  output logic                        backwards_o
);

  logic [epm_pkg::HIGH_W-1:0]  high_q, high_d, high_inc, high_use;
  logic                        pend_q, pend_d;
  logic [epm_pkg::STAMP_W-1:0] prev_q, prev_d, per_q, per_d, stamp;
  logic                        bw_q, bw_d;
  logic [TIMER_BITS-1:0]       low;
  logic                        take;
  logic [63:0]                 stamp_wide;

  assign low        = TIMER_BITS'(capture_value_i);
  assign take       = pend_q && !low[TIMER_BITS-1];
  assign high_inc   = high_q + 16'd1;
  assign high_use   = take ? high_inc : high_q;
  assign stamp_wide = (64'(high_use) << TIMER_BITS) | 64'(low);
  assign stamp      = stamp_wide[epm_pkg::STAMP_W-1:0];

  always_comb begin
    high_d = high_q;
    pend_d = pend_q;
    prev_d = prev_q;
    per_d  = per_q;
    bw_d   = bw_q;
    if (ev_valid_i) begin
      case (command_i)
        epm_pkg::CMD_WRAP: begin
          pend_d = 1'b1;
        end
        epm_pkg::CMD_SERVICE: begin
          if (pend_q) begin
            high_d = high_inc;
            pend_d = 1'b0;
          end
        end
        epm_pkg::CMD_CAPTURE: begin
          if (take) begin
            high_d = high_inc;
            pend_d = 1'b0;
          end
          per_d  = stamp - prev_q;
          bw_d   = prev_q > stamp;
          prev_d = stamp;
        end
        default: begin
          pend_d = pend_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q <= '0;
      pend_q <= 1'b0;
      prev_q <= '0;
      per_q  <= '0;
      bw_q   <= 1'b0;
    end else begin
      high_q <= high_d;
      pend_q <= pend_d;
      prev_q <= prev_d;
      per_q  <= per_d;
      bw_q   <= bw_d;
    end
  end

  assign period_o    = per_q;
  assign backwards_o = bw_q;

endmodule

// ----- src/epm_div.sv -----
// Shared restoring divider, one quotient bit per cycle
`include "assert_macros.svh"

module epm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  epm_pkg::div_req_t           req_i,
  output logic                        done_o,
  output logic [epm_pkg::DIV_W-1:0]   quot_o
);

  logic                          busy_q, busy_d, done_q, done_d;
  logic [epm_pkg::STEP_W-1:0]    cnt_q, cnt_d;
  logic [epm_pkg::REM_W-1:0]     rem_q, rem_d, rem_sh, rem_sub;
  logic [epm_pkg::DIV_W-1:0]     sh_q, sh_d, quot_q, quot_d;
  logic [epm_pkg::DEN_W-1:0]     den_q, den_d;
  logic                          ge;

  assign rem_sh  = {rem_q[epm_pkg::REM_W-2:0], sh_q[epm_pkg::DIV_W-1]};
  assign ge      = rem_sh >= epm_pkg::REM_W'(den_q);
  assign rem_sub = rem_sh - epm_pkg::REM_W'(den_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    quot_d = quot_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem;
      sh_d   = req_i.dividend;
      den_d  = req_i.den;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? rem_sub : rem_sh;
      sh_d   = sh_q << 1;
      quot_d = {quot_q[epm_pkg::DIV_W-2:0], ge};
      cnt_d  = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  `EPM_NEVER(a_no_restart, clk_i, rst_ni, start_i && busy_q)
  `EPM_ASSERT(a_rem_below_den, clk_i, rst_ni, busy_q |-> rem_q < epm_pkg::REM_W'(den_q))

endmodule

// ----- src/encoder_period_meter_core.sv -----
// Encoder period meter top level: event tracking, binning and RPM sequencer
// Each event transfer yields one result. The timestamp update is done in the
// accept cycle; bin and RPM then run through one restoring divider, one
// quotient bit per cycle. With a power-of-two bin count the bin size is a
// shift; another bin count adds a division for the bin size. A zero period,
// a saturated RPM or a clamped bin skip their division. The next event is
// accepted once the result is parked in the output register, even if it has
// not been taken.
`include "assert_macros.svh"

module encoder_period_meter_core #(
  parameter int NUM_BINS   = epm_pkg::NUM_BINS_DEF,
  parameter int TIMER_BITS = epm_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  epm_in_if.sink                        in_chan,
  epm_out_if.source                     out_chan,
  input  logic                          cfg_we_i,
  input  logic [epm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [epm_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int BINS_LOG  = $clog2(NUM_BINS);
  localparam bit BINS_POW2 = (1 << BINS_LOG) == NUM_BINS;
  localparam int BIN_QB    = (NUM_BINS > 1) ? BINS_LOG : 1;
  localparam int BIN_IW    = BIN_QB + 1;
  localparam logic [BIN_IW-1:0] BIN_MAX = BIN_IW'(NUM_BINS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_SIZE   = 3'd2;
  localparam logic [2:0] ST_BIN    = 3'd3;
  localparam logic [2:0] ST_BINDIV = 3'd4;
  localparam logic [2:0] ST_RPM    = 3'd5;
  localparam logic [2:0] ST_RPMDIV = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  // configuration
  logic [epm_pkg::TPM_W-1:0]   tpm_q;
  logic [epm_pkg::GEAR_W-1:0]  gear_q;
  logic [epm_pkg::PPR_W-1:0]   ppr_q;
  logic [epm_pkg::STAMP_W-1:0] floor_q, ceil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q   <= epm_pkg::TPM_RST;
      gear_q  <= epm_pkg::GEAR_RST;
      ppr_q   <= epm_pkg::PPR_RST;
      floor_q <= epm_pkg::FLOOR_RST;
      ceil_q  <= epm_pkg::CEIL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        epm_pkg::CFG_TPM:   tpm_q   <= cfg_data_i;
        epm_pkg::CFG_GEAR:  gear_q  <= cfg_data_i[epm_pkg::GEAR_W-1:0];
        epm_pkg::CFG_PPR:   ppr_q   <= cfg_data_i[epm_pkg::PPR_W-1:0];
        epm_pkg::CFG_FLOOR: floor_q <= cfg_data_i;
        epm_pkg::CFG_CEIL:  ceil_q  <= cfg_data_i;
        default: begin
          tpm_q <= tpm_q;
        end
      endcase
    end
  end

  // event tracking
  logic                        in_xfer;
  logic [epm_pkg::STAMP_W-1:0] period;
  logic                        backwards;
  logic [2:0]                  state_q, state_d;

  assign in_chan.ready = (state_q == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  epm_stamp #(
    .TIMER_BITS (TIMER_BITS)
  ) u_stamp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ev_valid_i      (in_xfer),
    .command_i       (in_chan.command),
    .capture_value_i (in_chan.capture_value),
    .period_o        (period),
    .backwards_o     (backwards)
  );

  // shared divider
  logic                      div_start, div_done;
  epm_pkg::div_req_t         div_req;
  logic [epm_pkg::DIV_W-1:0] div_quot;

  epm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // sequencer datapath
  logic [epm_pkg::GP_W-1:0]    gp_q, gp_d;
  logic [epm_pkg::NUM_W-1:0]   num_q, num_d;
  logic [epm_pkg::DEN_W-1:0]   den_q, den_d;
  logic [epm_pkg::STAMP_W-1:0] size_q, size_d;
  logic [BIN_IW-1:0]           bin_q, bin_d;
  logic [epm_pkg::RPM_W-1:0]   rpm_q, rpm_d;
  logic [epm_pkg::STAMP_W-1:0] span, p_lo, p_cl, p_off;
  logic [BIN_IW-1:0]           bin_inc;
  logic                        div_wait;

  logic                        out_valid_q, out_valid_d, out_load;
  logic [epm_pkg::STAMP_W-1:0] out_period_q;
  logic [BIN_IW-1:0]           out_bin_q;
  logic [epm_pkg::RPM_W-1:0]   out_rpm_q;
  logic                        out_bw_q;

  assign span     = (ceil_q > floor_q) ? (ceil_q - floor_q) : '0;
  assign p_lo     = (period < floor_q) ? floor_q : period;
  assign p_cl     = (p_lo > ceil_q) ? ceil_q : p_lo;
  assign p_off    = p_cl - floor_q;
  assign bin_inc  = {1'b0, div_quot[BIN_QB-1:0]} + BIN_IW'(1);
  assign div_wait = (state_q == ST_SIZE) || (state_q == ST_BINDIV) || (state_q == ST_RPMDIV);

  always_comb begin
    state_d   = state_q;
    gp_d      = gp_q;
    num_d     = num_q;
    den_d     = den_q;
    size_d    = size_q;
    bin_d     = bin_q;
    rpm_d     = rpm_q;
    div_start = 1'b0;
    div_req   = '0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        gp_d  = epm_pkg::GP_W'(gear_q) * epm_pkg::GP_W'(ppr_q);
        num_d = epm_pkg::NUM_W'(tpm_q) * epm_pkg::NUM_W'(epm_pkg::RPM_SCALE);
        if (BINS_POW2) begin
          size_d  = span >> BINS_LOG;
          state_d = ST_BIN;
        end else begin
          div_start        = 1'b1;
          div_req.rem      = '0;
          div_req.dividend = span;
          div_req.den      = epm_pkg::DEN_W'(NUM_BINS);
          div_req.steps    = epm_pkg::STEP_W'(epm_pkg::DIV_W);
          state_d          = ST_SIZE;
        end
      end
      ST_SIZE: begin
        if (div_done) begin
          size_d  = div_quot;
          state_d = ST_BIN;
        end
      end
      ST_BIN: begin
        den_d = epm_pkg::DEN_W'(gp_q) * epm_pkg::DEN_W'(period);
        if (size_q == '0 || (p_off >> BIN_QB) >= size_q) begin
          bin_d   = BIN_MAX;
          state_d = ST_RPM;
        end else begin
          div_start        = 1'b1;
          div_req.rem      = epm_pkg::REM_W'(p_off >> BIN_QB);
          div_req.dividend = p_off << (epm_pkg::DIV_W - BIN_QB);
          div_req.den      = epm_pkg::DEN_W'(size_q);
          div_req.steps    = epm_pkg::STEP_W'(BIN_QB);
          state_d          = ST_BINDIV;
        end
      end
      ST_BINDIV: begin
        if (div_done) begin
          bin_d   = (bin_inc > BIN_MAX) ? BIN_MAX : bin_inc;
          state_d = ST_RPM;
        end
      end
      ST_RPM: begin
        if (period == '0) begin
          rpm_d   = '0;
          state_d = ST_DONE;
        end else if (epm_pkg::DEN_W'(num_q[epm_pkg::NUM_W-1:epm_pkg::DIV_W]) >= den_q) begin
          // quotient would not fit in 32 bits
          rpm_d   = '1;
          state_d = ST_DONE;
        end else begin
          div_start        = 1'b1;
          div_req.rem      = epm_pkg::REM_W'(num_q[epm_pkg::NUM_W-1:epm_pkg::DIV_W]);
          div_req.dividend = num_q[epm_pkg::DIV_W-1:0];
          div_req.den      = den_q;
          div_req.steps    = epm_pkg::STEP_W'(epm_pkg::DIV_W);
          state_d          = ST_RPMDIV;
        end
      end
      ST_RPMDIV: begin
        if (div_done) begin
          rpm_d   = div_quot;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_chan.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_chan.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gp_q   <= gp_d;
    num_q  <= num_d;
    den_q  <= den_d;
    size_q <= size_d;
    bin_q  <= bin_d;
    rpm_q  <= rpm_d;
    if (out_load) begin
      out_period_q <= period;
      out_bin_q    <= bin_q;
      out_rpm_q    <= rpm_q;
      out_bw_q     <= backwards;
    end
  end

  assign out_chan.valid          = out_valid_q;
  assign out_chan.period_ticks   = out_period_q;
  assign out_chan.period_bin     = epm_pkg::BIN_W'(out_bin_q);
  assign out_chan.speed_rpm      = out_rpm_q;
  assign out_chan.went_backwards = out_bw_q;

  `EPM_ASSERT(a_accept_starts, clk_i, rst_ni, in_xfer |=> state_q == ST_PREP)
  `EPM_ASSERT(a_done_expected, clk_i, rst_ni, div_done |-> div_wait)
  `EPM_ASSERT(a_bin_range, clk_i, rst_ni, out_valid_q |-> (out_bin_q != '0 && out_bin_q <= BIN_MAX))

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the encoder period meter: event driver, result checker, predictor
module tb;
  import epm_pkg::*;

  localparam logic [CMD_W-1:0]   CMD_UNUSED  = 2'd3;
  localparam logic [CAP_W-1:0]   HALF_RANGE  = 16'h8000;
  localparam logic [STAMP_W-1:0] NBINS_U     = NUM_BINS_DEF;
  localparam logic [1:0]         JOB_EVENT   = 2'd0;
  localparam logic [1:0]         JOB_REG     = 2'd1;
  localparam logic [1:0]         JOB_DRAIN   = 2'd2;
  localparam int                 LONG_HOLD   = 400;
  localparam int                 HOLD_AT_A   = 150;
  localparam int                 HOLD_AT_B   = 450;
  localparam int                 CALM_LO     = 560;
  localparam int                 CALM_HI     = 640;
  localparam int                 TAIL_CYCLES = 120;
  localparam int                 LIMIT       = 400000;

  typedef struct packed {
    logic [STAMP_W-1:0] period;
    logic [BIN_W-1:0]   bin;
    logic [RPM_W-1:0]   rpm;
    logic               backwards;
  } meas_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [CMD_W-1:0]     cmd;
    logic [CAP_W-1:0]     cap;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    logic [3:0]           gap;
  } job_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 ev_valid = 1'b0;
  logic [CMD_W-1:0]     ev_cmd = '0;
  logic [CAP_W-1:0]     ev_cap = '0;
  logic                 res_ready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  epm_in_if  ev_if ();
  epm_out_if res_if ();

  assign ev_if.valid         = ev_valid;
  assign ev_if.command       = ev_cmd;
  assign ev_if.capture_value = ev_cap;
  assign res_if.ready        = res_ready;

  encoder_period_meter_core u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_chan   (ev_if),
    .out_chan  (res_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor settings and state
  logic [TPM_W-1:0]   tpm_r   = TPM_RST;
  logic [GEAR_W-1:0]  gear_r  = GEAR_RST;
  logic [PPR_W-1:0]   ppr_r   = PPR_RST;
  logic [STAMP_W-1:0] floor_r = FLOOR_RST;
  logic [STAMP_W-1:0] ceil_r  = CEIL_RST;

  logic [HIGH_W-1:0]  roll_hi    = '0;
  logic [CAP_W-1:0]   cap_lo     = '0;
  logic               wrap_pend  = 1'b0;
  logic [STAMP_W-1:0] prev_stamp = '0;
  logic [STAMP_W-1:0] last_per   = '0;
  logic               went_back  = 1'b0;

  meas_t predicted[$];
  job_t  jobs[$];

  int         n_fail = 0;
  int         n_seen = 0;
  int         hold_left = 0;
  int         cycle_count = 0;
  logic [3:0] gap_left = '0;
  logic       armed = 1'b0;
  logic       calm_sender = 1'b0;
  logic [STAMP_W-1:0] sim_clock = '0;

  function automatic logic [BIN_W-1:0] bin_for(input logic [STAMP_W-1:0] p);
    logic [STAMP_W-1:0] span, size, b, q;
    span = (ceil_r > floor_r) ? ceil_r - floor_r : '0;
    size = span / NBINS_U;
    if (size == '0) return NBINS_U[BIN_W-1:0];
    q = p;
    if (q < floor_r) q = floor_r;
    if (q > ceil_r) q = ceil_r;
    b = (q - floor_r) / size + 1;
    if (b > NBINS_U) b = NBINS_U;
    return b[BIN_W-1:0];
  endfunction

  function automatic logic [RPM_W-1:0] rpm_for(input logic [STAMP_W-1:0] p);
    logic [63:0] num, den, quo;
    num = tpm_r;
    num = num * RPM_SCALE;
    den = gear_r;
    den = den * ppr_r;
    den = den * p;
    if (p == '0) return '0;
    if (den == '0) return '1;
    quo = num / den;
    return (quo > 64'hFFFF_FFFF) ? '1 : quo[RPM_W-1:0];
  endfunction

  function automatic void load_setting(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] data);
    case (idx)
      CFG_TPM:   tpm_r = data;
      CFG_GEAR:  gear_r = data[GEAR_W-1:0];
      CFG_PPR:   ppr_r = data[PPR_W-1:0];
      CFG_FLOOR: floor_r = data;
      CFG_CEIL:  ceil_r = data;
      default: ;
    endcase
  endfunction

  function automatic void track_event(input logic [CMD_W-1:0] cmd,
                                      input logic [CAP_W-1:0] cap);
    meas_t              m;
    logic [STAMP_W-1:0] stamp;
    case (cmd)
      CMD_WRAP: wrap_pend = 1'b1;
      CMD_SERVICE: if (wrap_pend) begin
        roll_hi = roll_hi + 1'b1;
        wrap_pend = 1'b0;
      end
      CMD_CAPTURE: begin
        cap_lo = cap;
        // a pending wrap belongs to this capture only if the timer is early in its count
        if (wrap_pend && cap_lo < HALF_RANGE) begin
          roll_hi = roll_hi + 1'b1;
          wrap_pend = 1'b0;
        end
        stamp = {roll_hi, cap_lo};
        last_per = stamp - prev_stamp;
        went_back = prev_stamp > stamp;
        prev_stamp = stamp;
      end
      default: ;
    endcase
    m.period = last_per;
    m.bin = bin_for(last_per);
    m.rpm = rpm_for(last_per);
    m.backwards = went_back;
    predicted.push_back(m);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // event and register driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_events
    logic                 nv, nwe;
    logic [CMD_W-1:0]     ncmd;
    logic [CAP_W-1:0]     ncap;
    logic [CFG_IDX_W-1:0] nidx;
    logic [CFG_W-1:0]     ndata;
    job_t                 head;
    if (!rst_ni) begin
      ev_valid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      nv = ev_valid;
      ncmd = ev_cmd;
      ncap = ev_cap;
      nwe = 1'b0;
      nidx = cfg_idx;
      ndata = cfg_data;
      if (ev_valid && ev_if.ready) begin
        track_event(ev_cmd, ev_cap);
        nv = 1'b0;
      end
      if (!nv && jobs.size() != 0) begin
        head = jobs[0];
        if (!armed) begin
          gap_left = head.gap;
          armed = 1'b1;
        end
        case (head.kind)
          JOB_EVENT: if (gap_left != 0) begin
            gap_left = gap_left - 1'b1;
          end else begin
            nv = 1'b1;
            ncmd = head.cmd;
            ncap = head.cap;
            void'(jobs.pop_front());
            armed = 1'b0;
          end
          JOB_REG: if (predicted.size() == 0) begin
            nwe = 1'b1;
            nidx = head.idx;
            ndata = head.data;
            load_setting(head.idx, head.data);
            void'(jobs.pop_front());
            armed = 1'b0;
          end
          default: if (predicted.size() == 0) begin
            void'(jobs.pop_front());
            armed = 1'b0;
          end
        endcase
      end
      ev_valid <= nv;
      ev_cmd <= ncmd;
      ev_cap <= ncap;
      cfg_we <= nwe;
      cfg_idx <= nidx;
      cfg_data <= ndata;
    end
  end

  // result checker and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    meas_t want;
    if (!rst_ni) begin
      res_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (res_if.valid && res_ready) begin
        if (predicted.size() == 0) begin
          $error("result transfer with no event outstanding");
          n_fail++;
        end else begin
          want = predicted.pop_front();
          check_field("period_ticks", want.period, res_if.period_ticks);
          check_field("period_bin", 32'(want.bin), 32'(res_if.period_bin));
          check_field("speed_rpm", want.rpm, res_if.speed_rpm);
          check_field("went_backwards", 32'(want.backwards), 32'(res_if.went_backwards));
        end
        n_seen++;
        if (n_seen == HOLD_AT_A || n_seen == HOLD_AT_B) hold_left = LONG_HOLD;
        else if (n_seen >= CALM_LO && n_seen < CALM_HI) hold_left = 0;
        else hold_left = $urandom_range(11, 0);
      end else if (hold_left != 0) begin
        hold_left--;
      end
      res_ready <= (hold_left == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_event(input logic [CMD_W-1:0] cmd, input logic [CAP_W-1:0] cap);
    job_t j;
    j = '0;
    j.kind = JOB_EVENT;
    j.cmd = cmd;
    j.cap = cap;
    j.gap = calm_sender ? 4'd0 : 4'($urandom_range(11, 0));
    jobs.push_back(j);
  endtask

  task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    job_t j;
    j = '0;
    j.kind = JOB_REG;
    j.idx = idx;
    j.data = data;
    jobs.push_back(j);
  endtask

  task automatic add_drain();
    job_t j;
    j = '0;
    j.kind = JOB_DRAIN;
    jobs.push_back(j);
  endtask

  task automatic add_settings(input logic [CFG_W-1:0] tpm, input logic [CFG_W-1:0] gear,
                              input logic [CFG_W-1:0] ppr, input logic [CFG_W-1:0] fl,
                              input logic [CFG_W-1:0] ce);
    add_reg(CFG_TPM, tpm);
    add_reg(CFG_GEAR, gear);
    add_reg(CFG_PPR, ppr);
    add_reg(CFG_FLOOR, fl);
    add_reg(CFG_CEIL, ce);
  endtask

  // a running timer with encoder edges; wraps as they fall, service now and then, some noise
  task automatic add_motion(input int n, input int unsigned lo, input int unsigned hi,
                            input int unsigned noise_pct);
    logic [STAMP_W-1:0] nxt;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99, 0) < noise_pct) begin
        add_event(2'($urandom_range(3, 0)), 16'($urandom));
      end else begin
        nxt = sim_clock + $urandom_range(hi, lo);
        if (nxt[31:16] != sim_clock[31:16]) begin
          add_event(CMD_WRAP, 16'($urandom));
          if ($urandom_range(1, 0) == 1) add_event(CMD_SERVICE, 16'($urandom));
        end
        sim_clock = nxt;
        add_event(CMD_CAPTURE, nxt[15:0]);
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] fl;

    // directed: reset settings, zero period, unused command, backwards, rollover paths
    add_event(CMD_CAPTURE, 16'h0000);
    add_event(CMD_UNUSED, 16'hFFFF);
    add_event(CMD_CAPTURE, 16'hFFFF);
    add_event(CMD_CAPTURE, 16'h0000);
    add_event(CMD_WRAP, 16'hA5A5);
    add_event(CMD_SERVICE, 16'h5A5A);
    add_event(CMD_SERVICE, 16'h0000);
    add_event(CMD_CAPTURE, 16'h2710);
    add_event(CMD_WRAP, 16'h0000);
    add_event(CMD_CAPTURE, 16'h7FFF);
    add_event(CMD_WRAP, 16'h0000);
    add_event(CMD_CAPTURE, 16'h8000);
    add_event(CMD_SERVICE, 16'h0000);
    add_event(CMD_CAPTURE, 16'hC350);
    add_event(CMD_CAPTURE, 16'hC350);
    // RPM saturation
    add_reg(CFG_GEAR, 32'd1);
    add_reg(CFG_PPR, 32'd1);
    add_reg(CFG_TPM, 32'hFFFF_FFFF);
    add_event(CMD_CAPTURE, 16'hC351);
    // zero gear, then zero pulse count
    add_reg(CFG_GEAR, 32'd0);
    add_event(CMD_CAPTURE, 16'hD000);
    add_reg(CFG_GEAR, 32'd1023);
    add_reg(CFG_PPR, 32'd0);
    add_event(CMD_CAPTURE, 16'hE000);
    // ceiling below floor, equal, and a span too narrow for the bins
    add_reg(CFG_PPR, 32'd65535);
    add_reg(CFG_FLOOR, 32'd30000);
    add_reg(CFG_CEIL, 32'd20000);
    add_event(CMD_CAPTURE, 16'hE100);
    add_reg(CFG_FLOOR, 32'd20000);
    add_event(CMD_CAPTURE, 16'hF000);
    add_reg(CFG_FLOOR, 32'd5);
    add_reg(CFG_CEIL, 32'd12);
    add_event(CMD_CAPTURE, 16'hF005);
    add_reg(CFG_FLOOR, 32'd0);
    add_reg(CFG_CEIL, 32'hFFFF_FFFF);
    add_event(CMD_CAPTURE, 16'hFFFF);
    add_event(CMD_WRAP, 16'hFFFF);
    add_event(CMD_CAPTURE, 16'h0001);

    // random phases
    add_settings(TPM_RST, GEAR_RST, PPR_RST, FLOOR_RST, CEIL_RST);
    add_motion(90, 8000, 30000, 10);
    add_settings(32'hFFFF_FFFF, 32'd1023, 32'd65535, 32'd0, 32'hFFFF_FFFF);
    add_motion(90, 0, 65535, 10);
    add_settings(32'd1, 32'd1, 32'd1, 32'd100, 32'd107);
    add_motion(90, 0, 300, 10);
    fl = $urandom_range(20000, 0);
    add_settings($urandom_range(32'hFFFF_FFFF, 1), $urandom_range(1023, 1),
                 $urandom_range(65535, 1), fl, fl + $urandom_range(50000, 8));
    add_motion(45, 0, 40000, 10);
    add_drain();
    add_motion(45, 0, 40000, 10);
    add_settings($urandom_range(32'hFFFF_FFFF, 1), $urandom_range(1023, 1),
                 $urandom_range(65535, 1), 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    add_motion(90, 0, 20000, 40);
    add_settings(32'd600000, 32'd10, 32'd4, 32'd20, 32'd100);
    calm_sender = 1'b1;
    add_motion(45, 0, 200, 10);
    calm_sender = 1'b0;
    add_motion(45, 0, 200, 10);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (jobs.size() != 0 || predicted.size() != 0 || ev_valid);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (predicted.size() != 0) begin
      $error("%0d expected results never arrived", predicted.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/epm_pkg.sv
src/epm_if.sv
src/epm_stamp.sv
src/epm_div.sv
src/encoder_period_meter_core.sv
bench/tb.sv
